### design/apm_pkg.sv
// Shared types and constants for the AC power meter.
// Beat payloads and unit request/response structs; no dependencies.
package apm_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned ACC_BITS    = 64;
  localparam int unsigned OPND_BITS   = TIME_BITS + 1;
  localparam int unsigned PROD_BITS   = 2 * OPND_BITS;
  localparam int unsigned DIV_STEPS   = ACC_BITS;
  localparam int unsigned SQRT_STEPS  = ACC_BITS / 2;
  localparam int unsigned ROOT_BITS   = ACC_BITS / 2;
  localparam int unsigned REM_BITS    = ROOT_BITS + 4;

  localparam logic [31:0] HALF_PERIOD_RESET = 32'd10000;
  localparam logic [31:0] PHASE_SCALE       = 32'd18000;
  localparam logic [15:0] PHASE_MAX         = 16'd36000;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [15:0] voltage;
    logic signed [15:0] current;
    logic               last_sample;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]        voltage_rms;
    logic [15:0]        current_rms;
    logic signed [31:0] mean_power;
    logic [31:0]        crossing_time;
    logic               crossing_found;
    logic [15:0]        phase_centideg;
    logic               span_error;
  } out_beat_t;

  typedef struct packed {
    logic                        en;
    logic signed [OPND_BITS-1:0] a;
    logic signed [OPND_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                  start;
    logic [ACC_BITS-1:0]   dividend;
    logic [OPND_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [ACC_BITS-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                start;
    logic [ACC_BITS-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] root;
  } sqrt_rsp_t;

endpackage

### design/apm_mul.sv
// Registered signed multiplier shared by all product steps.
// Depends on apm_pkg.
module apm_mul (
  input  logic                                clk_i,
  input  apm_pkg::mul_req_t                   req_i,
  output logic signed [apm_pkg::PROD_BITS-1:0] prod_o
);
  import apm_pkg::*;

  logic signed [PROD_BITS-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= PROD_BITS'(req_i.a) * PROD_BITS'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

### design/apm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on apm_pkg.
module apm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apm_pkg::div_req_t req_i,
  output apm_pkg::div_rsp_t rsp_o
);
  import apm_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(DIV_STEPS + 1);

  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [ACC_BITS-1:0]  quo_q, quo_d;
  logic [OPND_BITS:0]   rem_q, rem_d;
  logic [OPND_BITS-1:0] dvs_q, dvs_d;
  logic [OPND_BITS:0]   rem_sh;
  logic                 ge;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    rem_sh = {rem_q[OPND_BITS-1:0], quo_q[ACC_BITS-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CNT_BITS'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[ACC_BITS-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### design/apm_sqrt.sv
// Serial integer square root, one root bit per cycle.
// Depends on apm_pkg.
module apm_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apm_pkg::sqrt_req_t req_i,
  output apm_pkg::sqrt_rsp_t rsp_o
);
  import apm_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(SQRT_STEPS + 1);

  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [ACC_BITS-1:0]  rad_q, rad_d;
  logic [REM_BITS-1:0]  rem_q, rem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic [REM_BITS-1:0]  rem_sh;
  logic [REM_BITS-1:0]  trial;
  logic                 ge;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    done_d = 1'b0;
    rem_sh = {rem_q[REM_BITS-3:0], rad_q[ACC_BITS-1:ACC_BITS-2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
    if (req_i.start) begin
      rad_d  = req_i.radicand;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_BITS'(SQRT_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[ACC_BITS-3:0], 2'b00};
      rem_d  = ge ? rem_sh - trial : rem_sh;
      root_d = {root_q[ROOT_BITS-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

### design/ac_power_meter.sv
// AC power meter top level: sequencer, record state and result register.
// Depends on apm_pkg, apm_mul, apm_div and apm_sqrt.
// A first sample of a record only opens it; any other runs the multiply
// steps and, on a rising current crossing, the 64-step divider. One beat is
// taken at a time. A last sample adds three divides, two 32-step roots (for a
// nonzero span), a phase multiply and divide (crossing seen) and output stalls.
// Reset clears the record and sets the half period to 10000 ticks.
module ac_power_meter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  apm_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output apm_pkg::out_beat_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import apm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_M1  = 5'd1,  S_M2  = 5'd2,  S_M3  = 5'd3;
  localparam logic [4:0] S_M4   = 5'd4,  S_M5  = 5'd5,  S_M6  = 5'd6,  S_M7  = 5'd7;
  localparam logic [4:0] S_M8   = 5'd8,  S_M9  = 5'd9,  S_M10 = 5'd10, S_M11 = 5'd11;
  localparam logic [4:0] S_XDIV = 5'd12, S_XWT = 5'd13, S_UPD = 5'd14, S_FIN = 5'd15;
  localparam logic [4:0] S_FVD  = 5'd16, S_FVW = 5'd17, S_FVS = 5'd18, S_FCD = 5'd19;
  localparam logic [4:0] S_FCW  = 5'd20, S_FCS = 5'd21, S_FPD = 5'd22, S_FPW = 5'd23;
  localparam logic [4:0] S_FH0  = 5'd24, S_FH1 = 5'd25, S_FHW = 5'd26, S_OUT = 5'd27;

  logic [4:0] state_q, state_d;

  logic [31:0]                 hp_q;
  in_beat_t                    cur_q, cur_d;
  logic                        have_q, have_d;
  logic [31:0]                 first_q, first_d;
  logic [31:0]                 pt_q, pt_d;
  logic signed [15:0]          pv_q, pv_d, pc_q, pc_d;
  logic [ACC_BITS-1:0]         svv_q, svv_d, scc_q, scc_d;
  logic signed [ACC_BITS-1:0]  sp_q, sp_d;
  logic [31:0]                 lc_q, lc_d;
  logic                        seen_q, seen_d;
  logic signed [OPND_BITS-1:0] avv_q, avv_d, acc_q, acc_d, ap_q, ap_d;
  logic [OPND_BITS-1:0]        den_q, den_d;
  logic [15:0]                 vr_q, vr_d, ir_q, ir_d, ph_q, ph_d;
  logic signed [31:0]          pw_q, pw_d;
  logic                        serr_q, serr_d;
  logic                        ovalid_q, ovalid_d;
  out_beat_t                   out_q, out_d;

  mul_req_t                    mreq;
  logic signed [PROD_BITS-1:0] prod;
  div_req_t                    dreq;
  div_rsp_t                    drsp;
  sqrt_req_t                   sreq;
  sqrt_rsp_t                   srsp;

  logic [31:0]                 dt, span;
  logic [ACC_BITS:0]           uadd_v, uadd_c;
  logic signed [ACC_BITS-1:0]  sadd;
  logic signed [ACC_BITS-1:0]  pterm;
  logic [ACC_BITS-1:0]         pmag;
  logic [ACC_BITS-1:0]         q;
  logic                        out_free;

  function automatic logic signed [OPND_BITS-1:0] sx(input logic signed [15:0] x);
    return OPND_BITS'(x);
  endfunction

  apm_mul u_mul (.clk_i(clk_i), .req_i(mreq), .prod_o(prod));
  apm_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));
  apm_sqrt u_sqrt (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(sreq), .rsp_o(srsp));

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  assign dt     = cur_q.sample_time - pt_q;
  assign span   = cur_q.sample_time - first_q;
  assign q      = drsp.quotient;
  assign pterm  = prod[ACC_BITS-1:0];
  assign uadd_v = {1'b0, svv_q} + {1'b0, prod[ACC_BITS-1:0]};
  assign uadd_c = {1'b0, scc_q} + {1'b0, prod[ACC_BITS-1:0]};
  assign sadd   = sp_q + pterm;
  assign pmag   = sp_q[ACC_BITS-1] ? ACC_BITS'(-sp_q) : ACC_BITS'(sp_q);
  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    have_d   = have_q;
    first_d  = first_q;
    pt_d     = pt_q;
    pv_d     = pv_q;
    pc_d     = pc_q;
    svv_d    = svv_q;
    scc_d    = scc_q;
    sp_d     = sp_q;
    lc_d     = lc_q;
    seen_d   = seen_q;
    avv_d    = avv_q;
    acc_d    = acc_q;
    ap_d     = ap_q;
    den_d    = den_q;
    vr_d     = vr_q;
    ir_d     = ir_q;
    pw_d     = pw_q;
    ph_d     = ph_q;
    serr_d   = serr_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && out_stall_i;
    mreq     = '{en: 1'b0, a: '0, b: '0};
    dreq     = '{start: 1'b0, dividend: '0, divisor: '0};
    sreq     = '{start: 1'b0, radicand: '0};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d = in_data_i;
          if (!have_q) begin
            have_d  = 1'b1;
            first_d = in_data_i.sample_time;
            state_d = S_UPD;
          end else begin
            state_d = S_M1;
          end
        end
      end
      S_M1: begin
        mreq    = '{en: 1'b1, a: sx(cur_q.voltage), b: sx(cur_q.voltage)};
        state_d = S_M2;
      end
      S_M2: begin
        avv_d   = prod[OPND_BITS-1:0];
        mreq    = '{en: 1'b1, a: sx(pv_q), b: sx(pv_q)};
        state_d = S_M3;
      end
      S_M3: begin
        avv_d   = avv_q + prod[OPND_BITS-1:0];
        mreq    = '{en: 1'b1, a: sx(cur_q.current), b: sx(cur_q.current)};
        state_d = S_M4;
      end
      S_M4: begin
        acc_d   = prod[OPND_BITS-1:0];
        mreq    = '{en: 1'b1, a: sx(pc_q), b: sx(pc_q)};
        state_d = S_M5;
      end
      S_M5: begin
        acc_d   = acc_q + prod[OPND_BITS-1:0];
        mreq    = '{en: 1'b1, a: sx(cur_q.voltage), b: sx(cur_q.current)};
        state_d = S_M6;
      end
      S_M6: begin
        ap_d    = prod[OPND_BITS-1:0];
        mreq    = '{en: 1'b1, a: sx(pv_q), b: sx(pc_q)};
        state_d = S_M7;
      end
      S_M7: begin
        ap_d    = ap_q + prod[OPND_BITS-1:0];
        mreq    = '{en: 1'b1, a: avv_q, b: {1'b0, dt}};
        state_d = S_M8;
      end
      S_M8: begin
        svv_d   = uadd_v[ACC_BITS] ? '1 : uadd_v[ACC_BITS-1:0];
        mreq    = '{en: 1'b1, a: acc_q, b: {1'b0, dt}};
        state_d = S_M9;
      end
      S_M9: begin
        scc_d   = uadd_c[ACC_BITS] ? '1 : uadd_c[ACC_BITS-1:0];
        mreq    = '{en: 1'b1, a: ap_q, b: {1'b0, dt}};
        state_d = S_M10;
      end
      S_M10: begin
        if (sp_q[ACC_BITS-1] == pterm[ACC_BITS-1] && sadd[ACC_BITS-1] != sp_q[ACC_BITS-1]) begin
          sp_d = sp_q[ACC_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                  : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
          sp_d = sadd;
        end
        mreq    = '{en: 1'b1, a: -sx(pc_q), b: {1'b0, dt}};
        state_d = S_M11;
      end
      S_M11: begin
        if (pc_q < 0 && cur_q.current > 0) begin
          state_d = S_XDIV;
        end else begin
          state_d = S_UPD;
        end
      end
      S_XDIV: begin
        dreq    = '{start: 1'b1, dividend: prod[ACC_BITS-1:0],
                    divisor: sx(cur_q.current) - sx(pc_q)};
        state_d = S_XWT;
      end
      S_XWT: begin
        if (drsp.done) begin
          lc_d    = pt_q + q[31:0];
          seen_d  = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        pt_d    = cur_q.sample_time;
        pv_d    = cur_q.voltage;
        pc_d    = cur_q.current;
        state_d = cur_q.last_sample ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        den_d  = {span, 1'b0};
        serr_d = (span == '0);
        vr_d   = '0;
        ir_d   = '0;
        pw_d   = '0;
        ph_d   = '0;
        if (span != '0) begin
          state_d = S_FVD;
        end else begin
          state_d = seen_q ? S_FH0 : S_OUT;
        end
      end
      S_FVD: begin
        dreq    = '{start: 1'b1, dividend: svv_q, divisor: den_q};
        state_d = S_FVW;
      end
      S_FVW: begin
        if (drsp.done) begin
          sreq    = '{start: 1'b1, radicand: q};
          state_d = S_FVS;
        end
      end
      S_FVS: begin
        if (srsp.done) begin
          vr_d    = (srsp.root > ROOT_BITS'(16'hFFFF)) ? 16'hFFFF : srsp.root[15:0];
          state_d = S_FCD;
        end
      end
      S_FCD: begin
        dreq    = '{start: 1'b1, dividend: scc_q, divisor: den_q};
        state_d = S_FCW;
      end
      S_FCW: begin
        if (drsp.done) begin
          sreq    = '{start: 1'b1, radicand: q};
          state_d = S_FCS;
        end
      end
      S_FCS: begin
        if (srsp.done) begin
          ir_d    = (srsp.root > ROOT_BITS'(16'hFFFF)) ? 16'hFFFF : srsp.root[15:0];
          state_d = S_FPD;
        end
      end
      S_FPD: begin
        dreq    = '{start: 1'b1, dividend: pmag, divisor: den_q};
        state_d = S_FPW;
      end
      S_FPW: begin
        if (drsp.done) begin
          if (sp_q[ACC_BITS-1]) begin
            pw_d = (q > ACC_BITS'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
          end else begin
            pw_d = (q > ACC_BITS'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
          end
          state_d = seen_q ? S_FH0 : S_OUT;
        end
      end
      S_FH0: begin
        mreq    = '{en: 1'b1, a: {1'b0, PHASE_SCALE}, b: {1'b0, lc_q}};
        state_d = S_FH1;
      end
      S_FH1: begin
        dreq    = '{start: 1'b1, dividend: prod[ACC_BITS-1:0], divisor: {1'b0, hp_q}};
        state_d = S_FHW;
      end
      S_FHW: begin
        if (drsp.done) begin
          ph_d    = (q > ACC_BITS'(PHASE_MAX)) ? PHASE_MAX : q[15:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_d.voltage_rms    = vr_q;
          out_d.current_rms    = ir_q;
          out_d.mean_power     = pw_q;
          out_d.crossing_time  = seen_q ? lc_q : '0;
          out_d.crossing_found = seen_q;
          out_d.phase_centideg = ph_q;
          out_d.span_error     = serr_q;
          ovalid_d = 1'b1;
          have_d   = 1'b0;
          first_d  = '0;
          pt_d     = '0;
          pv_d     = '0;
          pc_d     = '0;
          svv_d    = '0;
          scc_d    = '0;
          sp_d     = '0;
          lc_d     = '0;
          seen_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hp_q     <= HALF_PERIOD_RESET;
      have_q   <= 1'b0;
      first_q  <= '0;
      pt_q     <= '0;
      pv_q     <= '0;
      pc_q     <= '0;
      svv_q    <= '0;
      scc_q    <= '0;
      sp_q     <= '0;
      lc_q     <= '0;
      seen_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_valid_i) begin
        hp_q <= cfg_data_i;
      end
      have_q   <= have_d;
      first_q  <= first_d;
      pt_q     <= pt_d;
      pv_q     <= pv_d;
      pc_q     <= pc_d;
      svv_q    <= svv_d;
      scc_q    <= scc_d;
      sp_q     <= sp_d;
      lc_q     <= lc_d;
      seen_q   <= seen_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    avv_q  <= avv_d;
    acc_q  <= acc_d;
    ap_q   <= ap_d;
    den_q  <= den_d;
    vr_q   <= vr_d;
    ir_q   <= ir_d;
    pw_q   <= pw_d;
    ph_q   <= ph_d;
    serr_q <= serr_d;
    out_q  <= out_d;
  end

endmodule
